/* sv/ikr_pkg.sv */
`default_nettype none

package ikr_pkg;

    // fixed widths of the channel fields
    localparam int VALUE_W = 64;
    localparam int EXP_W   = 7;
    localparam int ROOT_W  = 64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a new word
        logic trial_init;  // form the candidate, acc = candidate
        logic mul;         // register the partial products
        logic acc;         // fold the products into the trial power
        logic keep;        // candidate fits: take it into the root
        logic next_bit;    // move to the next lower result bit
        logic finish;      // register the result
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic special;   // trivial radicand or degree, or degree at least the data width
        logic exceed;    // trial power is above the radicand
        logic last_mul;  // this fold is the last multiplication
        logic bit_zero;  // lowest result bit under test
    } t_sts;

endpackage

`default_nettype wire

/* sv/ikr_ctrl.sv */
`default_nettype none

module ikr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ikr_pkg::t_sts i_sts,
    output ikr_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_valid
);
    import ikr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_NEXT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_valid;
    t_cmd       cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.special) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                cmd.trial_init = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                if (i_sts.exceed) begin
                    n_state = S_NEXT;
                end else begin
                    cmd.acc = 1'b1;
                    if (i_sts.last_mul) begin
                        cmd.keep = 1'b1;
                        n_state  = S_NEXT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_NEXT: begin
                if (i_sts.bit_zero) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    cmd.next_bit = 1'b1;
                    n_state      = S_INIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= cmd.finish;
        end
    end

    assign o_cmd   = cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* sv/ikr_dp.sv */
`default_nettype none

module ikr_dp #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire ikr_pkg::t_cmd            i_cmd,
    input  wire logic [DATA_WIDTH-1:0]    i_value,
    input  wire logic [ikr_pkg::EXP_W-1:0] i_exponent,
    output ikr_pkg::t_sts                 o_sts,
    output logic [DATA_WIDTH-1:0]         o_root
);
    import ikr_pkg::*;

    // root of degree two or more fits in half the width
    localparam int W  = DATA_WIDTH;
    localparam int S  = (DATA_WIDTH + 1) / 2;
    localparam int BW = $clog2(S);
    localparam int PW = W + S;
    localparam logic [EXP_W-1:0] K_W = EXP_W'(DATA_WIDTH);

    logic [W-1:0]     r_a;
    logic [EXP_W-1:0] r_k;
    logic [S-1:0]     r_root;
    logic [BW-1:0]    r_bit;
    logic [S-1:0]     r_cand;
    logic [W-1:0]     r_acc;
    logic [EXP_W-1:0] r_cnt;
    logic [W-1:0]     r_phi;
    logic [2*S-1:0]   r_plo;
    logic [W-1:0]     r_out;

    logic [S-1:0]  cand;
    logic [PW-1:0] prod;
    logic          trivial;
    logic          special;

    // candidate: current root with the bit under test set
    assign cand = r_root | ({{(S-1){1'b0}}, 1'b1} << r_bit);

    // full trial product from the two registered halves
    assign prod = {r_phi, {S{1'b0}}} + PW'(r_plo);

    assign trivial = (r_a <= W'(1)) || (r_k <= EXP_W'(1));
    assign special = trivial || (r_k >= K_W);

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_value;
            r_k    <= i_exponent;
            r_root <= '0;
            r_bit  <= BW'(S - 1);
        end
        if (i_cmd.trial_init) begin
            r_cand <= cand;
            r_acc  <= W'(cand);
            r_cnt  <= r_k - EXP_W'(1);
        end
        // two narrow multipliers cover the wide power times the candidate
        if (i_cmd.mul) begin
            r_phi <= W'(r_acc[W-1:S]) * W'(r_cand);
            r_plo <= (2*S)'(r_acc[S-1:0]) * (2*S)'(r_cand);
        end
        if (i_cmd.acc) begin
            r_acc <= prod[W-1:0];
            r_cnt <= r_cnt - EXP_W'(1);
        end
        if (i_cmd.keep) begin
            r_root <= r_cand;
        end
        if (i_cmd.next_bit) begin
            r_bit <= r_bit - BW'(1);
        end
        if (i_cmd.finish) begin
            if (trivial) begin
                r_out <= r_a;
            end else if (special) begin
                r_out <= W'(1);
            end else begin
                r_out <= W'(r_root);
            end
        end
    end

    // status
    always_comb begin
        o_sts.special  = special;
        o_sts.exceed   = (prod > PW'(r_a));
        o_sts.last_mul = (r_cnt == EXP_W'(1));
        o_sts.bit_zero = (r_bit == '0);
    end

    assign o_root = r_out;

endmodule

`default_nettype wire

/* sv/integer_kth_root.sv */
`default_nettype none
// Integer k-th root: o_root = largest n with n**k <= value.
// Command channel: drive i_value and i_exponent with start; the word is taken
// at a rising edge where start is high and busy is low. busy stays high until
// the result is registered, and drops in the same cycle that o_valid pulses.
// Result channel: o_root is shown for exactly one cycle, marked by o_valid.
// The receiver cannot stall; a new word may be started in the o_valid cycle.
// Value 0 or 1, or degree 0 or 1, returns the value; degree >= DATA_WIDTH
// returns 1. These are settled in the check state, with no bit search.
// Otherwise the root is found bit by bit over (DATA_WIDTH+1)/2 result bits.
// Each bit passes the init state, then a multiply and a fold state per trial
// multiplication, then the next-bit state; a trial stops at the first product
// above the value, so a bit takes from 1 to k-1 multiplications. Each
// multiplication uses a pair of 32-bit multipliers (for 64-bit data) whose
// products are registered before the fold. One word is worked on at a time.
// Reset (synchronous, active low) returns the controller to idle and clears
// the strobe; a word in progress is dropped.
module integer_kth_root #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [ikr_pkg::VALUE_W-1:0] i_value,
    input  wire logic [ikr_pkg::EXP_W-1:0]   i_exponent,
    output logic                             o_valid,
    output logic [ikr_pkg::ROOT_W-1:0]       o_root
);
    import ikr_pkg::*;

    t_cmd                  cmd;
    t_sts                  sts;
    logic [DATA_WIDTH-1:0] root;

    // sequencer
    ikr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // search datapath on the low DATA_WIDTH bits of the value
    ikr_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_value    (i_value[DATA_WIDTH-1:0]),
        .i_exponent (i_exponent),
        .o_sts      (sts),
        .o_root     (root)
    );

    assign o_root = ROOT_W'(root);

endmodule

`default_nettype wire

/* sv/ikr_check.sv */
`default_nettype none

module ikr_check (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    // a result only appears once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // busy only ends by delivering a result
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy dropped without a result");

    // one result word lasts a single cycle
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind integer_kth_root ikr_check u_ikr_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire
